### rtl/iebm_pkg.sv
// Shared types and constants for the I2C EEPROM byte master.
// Holds beat payload structs, configuration struct, register indexes and reset values.
package iebm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_WAIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

    localparam logic [9:0]  HALF_PERIOD_RESET = 10'd60;
    localparam logic [19:0] WRITE_WAIT_RESET  = 20'd250000;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [7:0] CTRL_WRITE = 8'hA0;
    localparam logic [7:0] CTRL_READ  = 8'hA1;

    typedef struct packed {
        logic [9:0]  half_period_ticks;
        logic [19:0] write_wait_ticks;
        logic [7:0]  ack_timeout_ticks;
    } iebm_cfg_t;

    typedef struct packed {
        logic        start_req;
        logic        func;
        logic [10:0] mem_address;
        logic [7:0]  write_data;
        logic        sda_in;
    } iebm_in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } iebm_out_t;

endpackage

### rtl/i2c_eeprom_byte_master_core.sv
// Top level of the I2C master for a 24C16-style 2 KB EEPROM, one random byte per transfer.
// Depends on iebm_pkg, iebm_cfg and iebm_seq.
//
// Each input beat is one clock tick of the I2C bit sequencer and yields exactly one result
// beat with the SCL/SDA levels, busy, done, read byte and ack error for that tick. One beat
// is taken every cycle unless the result register is stalled: the whole tick update is a single
// pass through the sequencer's next-state logic into its state and result registers. s_ready
// stays high while the result register is empty or is being drained by m_ready. Write the
// configuration registers only while no transfer runs and no result is pending.
module i2c_eeprom_byte_master_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  iebm_pkg::iebm_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output iebm_pkg::iebm_out_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [iebm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [iebm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import iebm_pkg::*;

    iebm_cfg_t cfg;
    logic      s_fire;

    assign s_ready = !m_valid || m_ready;
    assign s_fire  = s_valid && s_ready;

    iebm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    iebm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_fire  (s_fire),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

### rtl/iebm_cfg.sv
// Configuration register file: half period, write wait and ack timeout.
// Depends on iebm_pkg.
module iebm_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [iebm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [iebm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output iebm_pkg::iebm_cfg_t              cfg
);
    import iebm_pkg::*;

    iebm_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RESET;
            cfg_reg.write_wait_ticks  <= WRITE_WAIT_RESET;
            cfg_reg.ack_timeout_ticks <= ACK_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_wdata[9:0];
                CFG_WRITE_WAIT:  cfg_reg.write_wait_ticks  <= cfg_wdata;
                CFG_ACK_TIMEOUT: cfg_reg.ack_timeout_ticks <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/iebm_seq.sv
// Bit-level I2C sequencer: one tick per input beat, result held in an output register.
// Depends on iebm_pkg.
module iebm_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  iebm_pkg::iebm_cfg_t cfg,
    input  logic                s_fire,
    input  iebm_pkg::iebm_in_t  s_data,
    input  logic                m_ready,
    output logic                m_valid,
    output iebm_pkg::iebm_out_t m_data
);
    import iebm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_HI, PH_START_LO,
        PH_TX_BIT_LO, PH_TX_BIT_HI, PH_TX_ACK_LO, PH_TX_ACK_HI,
        PH_RS_A, PH_RS_B, PH_RS_C,
        PH_RX_LOW, PH_RX_HIGH, PH_NACK_LOW, PH_NACK_HIGH,
        PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_WAIT, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BYTE_CTRL_WR, BYTE_ADDR, BYTE_DATA, BYTE_CTRL_RD
    } byte_sel_t;

    phase_t      phase_reg, phase_next;
    byte_sel_t   byte_reg, byte_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [19:0] tick_timer_reg, tick_timer_next;
    logic [10:0] saved_address_reg, saved_address_next;
    logic [7:0]  saved_data_reg, saved_data_next;
    logic        saved_func_reg, saved_func_next;
    logic        error_seen_reg, error_seen_next;
    logic        m_valid_reg, m_valid_next;
    iebm_out_t   m_data_reg, res;

    logic [9:0]  half;
    logic [19:0] timer_inc;
    logic        half_end;
    logic [3:0]  bit_inc;

    always_comb begin
        half      = (cfg.half_period_ticks == 10'd0) ? 10'd1 : cfg.half_period_ticks;
        timer_inc = tick_timer_reg + 20'd1;
        half_end  = timer_inc >= {10'd0, half};
        bit_inc   = bit_count_reg + 4'd1;

        phase_next         = phase_reg;
        byte_next          = byte_reg;
        bit_count_next     = bit_count_reg;
        shift_byte_next    = shift_byte_reg;
        tick_timer_next    = tick_timer_reg;
        saved_address_next = saved_address_reg;
        saved_data_next    = saved_data_reg;
        saved_func_next    = saved_func_reg;
        error_seen_next    = error_seen_reg;

        res.scl_level    = 1'b1;
        res.sda_pull_low = 1'b0;
        res.busy_res     = 1'b1;
        res.done_res     = 1'b0;
        res.read_data    = 8'd0;
        res.ack_error    = 1'b0;

        if (phase_reg != PH_IDLE && phase_reg != PH_DONE && phase_reg != PH_WAIT &&
            phase_reg != PH_TX_ACK_HI) begin
            tick_timer_next = half_end ? 20'd0 : timer_inc;
        end

        unique case (phase_reg)
            PH_IDLE: begin
                res.busy_res = 1'b0;
                if (s_data.start_req) begin
                    saved_func_next    = s_data.func;
                    saved_address_next = s_data.mem_address;
                    saved_data_next    = s_data.write_data;
                    error_seen_next    = 1'b0;
                    tick_timer_next    = 20'd0;
                    bit_count_next     = 4'd0;
                    phase_next         = PH_START_HI;
                end
            end
            PH_DONE: begin
                res.busy_res  = 1'b0;
                res.done_res  = 1'b1;
                res.ack_error = error_seen_reg;
                res.read_data = (saved_func_reg && !error_seen_reg) ? shift_byte_reg : 8'd0;
                phase_next      = PH_IDLE;
                tick_timer_next = 20'd0;
            end
            PH_START_HI: begin
                if (half_end) phase_next = PH_START_LO;
            end
            PH_START_LO: begin
                res.sda_pull_low = 1'b1;
                if (half_end) begin
                    shift_byte_next = CTRL_WRITE | {4'd0, saved_address_reg[10:8], 1'b0};
                    bit_count_next  = 4'd0;
                    byte_next       = BYTE_CTRL_WR;
                    phase_next      = PH_TX_BIT_LO;
                end
            end
            PH_TX_BIT_LO: begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = !shift_byte_reg[7];
                if (half_end) phase_next = PH_TX_BIT_HI;
            end
            PH_TX_BIT_HI: begin
                res.sda_pull_low = !shift_byte_reg[7];
                if (half_end) begin
                    shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                    if (bit_inc >= 4'd8) begin
                        bit_count_next = 4'd0;
                        phase_next     = PH_TX_ACK_LO;
                    end else begin
                        bit_count_next = bit_inc;
                        phase_next     = PH_TX_BIT_LO;
                    end
                end
            end
            PH_TX_ACK_LO: begin
                res.scl_level = 1'b0;
                if (half_end) phase_next = PH_TX_ACK_HI;
            end
            PH_TX_ACK_HI: begin
                if (!s_data.sda_in) begin
                    tick_timer_next = 20'd0;
                    case (byte_reg)
                        BYTE_CTRL_WR: begin
                            shift_byte_next = saved_address_reg[7:0];
                            bit_count_next  = 4'd0;
                            byte_next       = BYTE_ADDR;
                            phase_next      = PH_TX_BIT_LO;
                        end
                        BYTE_ADDR: begin
                            if (saved_func_reg) begin
                                phase_next = PH_RS_A;
                            end else begin
                                shift_byte_next = saved_data_reg;
                                bit_count_next  = 4'd0;
                                byte_next       = BYTE_DATA;
                                phase_next      = PH_TX_BIT_LO;
                            end
                        end
                        BYTE_DATA: phase_next = PH_STOP_A;
                        default: begin
                            shift_byte_next = 8'd0;
                            bit_count_next  = 4'd0;
                            phase_next      = PH_RX_LOW;
                        end
                    endcase
                end else begin
                    tick_timer_next = timer_inc;
                    if (timer_inc >= {12'd0, cfg.ack_timeout_ticks}) begin
                        error_seen_next = 1'b1;
                        tick_timer_next = 20'd0;
                        phase_next      = PH_STOP_A;
                    end
                end
            end
            PH_RS_A: begin
                res.scl_level = 1'b0;
                if (half_end) phase_next = PH_RS_B;
            end
            PH_RS_B: begin
                if (half_end) phase_next = PH_RS_C;
            end
            PH_RS_C: begin
                res.sda_pull_low = 1'b1;
                if (half_end) begin
                    shift_byte_next = CTRL_READ;
                    bit_count_next  = 4'd0;
                    byte_next       = BYTE_CTRL_RD;
                    phase_next      = PH_TX_BIT_LO;
                end
            end
            PH_RX_LOW: begin
                res.scl_level = 1'b0;
                if (half_end) phase_next = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
                if (half_end) begin
                    shift_byte_next = {shift_byte_reg[6:0], s_data.sda_in};
                    bit_count_next  = bit_inc;
                    phase_next      = (bit_inc >= 4'd8) ? PH_NACK_LOW : PH_RX_LOW;
                end
            end
            PH_NACK_LOW: begin
                res.scl_level = 1'b0;
                if (half_end) phase_next = PH_NACK_HIGH;
            end
            PH_NACK_HIGH: begin
                if (half_end) phase_next = PH_STOP_A;
            end
            PH_STOP_A: begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = 1'b1;
                if (half_end) phase_next = PH_STOP_B;
            end
            PH_STOP_B: begin
                res.sda_pull_low = 1'b1;
                if (half_end) phase_next = PH_STOP_C;
            end
            PH_STOP_C: begin
                if (half_end) begin
                    if (!error_seen_reg && !saved_func_reg && cfg.write_wait_ticks != 20'd0)
                        phase_next = PH_WAIT;
                    else
                        phase_next = PH_DONE;
                end
            end
            PH_WAIT: begin
                tick_timer_next = timer_inc;
                if (timer_inc >= cfg.write_wait_ticks) begin
                    tick_timer_next = 20'd0;
                    phase_next      = PH_DONE;
                end
            end
            default: begin
                res.busy_res = 1'b0;
                phase_next   = PH_IDLE;
            end
        endcase

        if (s_fire)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            byte_reg       <= BYTE_CTRL_WR;
            bit_count_reg  <= 4'd0;
            tick_timer_reg <= 20'd0;
            error_seen_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                phase_reg      <= phase_next;
                byte_reg       <= byte_next;
                bit_count_reg  <= bit_count_next;
                tick_timer_reg <= tick_timer_next;
                error_seen_reg <= error_seen_next;
            end
        end
        if (s_fire) begin
            shift_byte_reg    <= shift_byte_next;
            saved_address_reg <= saved_address_next;
            saved_data_reg    <= saved_data_next;
            saved_func_reg    <= saved_func_next;
            m_data_reg        <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/iebm_checker.sv
// Port-level assertions for the I2C EEPROM byte master, bound to the top level.
// Depends on iebm_pkg.
module iebm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input iebm_pkg::iebm_out_t m_data
);
    import iebm_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_ready_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.busy_res |-> m_data.scl_level && !m_data.sda_pull_low)
        else $error("bus not released when not busy");

    a_err_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.ack_error |-> m_data.done_res && !m_data.busy_res)
        else $error("ack error outside done beat");

    a_rdata_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.read_data != 8'd0) |-> m_data.done_res && !m_data.ack_error)
        else $error("read data outside error-free done beat");

endmodule

bind i2c_eeprom_byte_master_core iebm_checker u_iebm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
